// ===== design/cea_pkg.sv =====
// Shared types, constants and helper functions for the complex element-wise ALU.
package cea_pkg;

   localparam int DW  = 32;          // data width of one component
   localparam int FW  = 16;          // fraction bits
   localparam int PW  = 2 * DW;      // full product width
   localparam int SW  = PW + 2;      // sum of four products
   localparam int QW  = DW + 1;      // quotient bits kept by the divider
   localparam int NLO = QW - FW;     // numerator bits shifted in by the divider

   localparam logic signed [DW-1:0] FX_ONE  = DW'(64'd1 << FW);
   localparam logic [DW-1:0]        VAL_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0]        VAL_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [QW-1:0]        MAG_MIN = QW'(1) << (DW-1);

   typedef enum logic [3:0] {
      OP_CONJ  = 4'd0,
      OP_SCALE = 4'd1,
      OP_SHIFT = 4'd2,
      OP_NEG   = 4'd3,
      OP_ABS   = 4'd4,
      OP_SGN   = 4'd5,
      OP_INV   = 4'd6,
      OP_AXPBY = 4'd7,
      OP_ADD   = 4'd8,
      OP_SUB   = 4'd9,
      OP_MUL   = 4'd10,
      OP_DIV   = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   typedef struct packed {
      logic          sat;
      logic [DW-1:0] val;
   } satv_type;

   // Payload that rides along the square root and divider stages.
   typedef struct packed {
      op_type        op;
      logic          last;
      logic [DW-1:0] zr;
      logic [DW-1:0] zi;
      logic          sat;
      logic          nr_neg;
      logic [PW-1:0] nr_mag;
      logic          ni_neg;
      logic [PW-1:0] ni_mag;
      logic [PW-1:0] sqs;
   } pld_type;

   // Clamp a wide signed value to the component range.
   function automatic satv_type sat_wide(input logic signed [SW-1:0] v);
      satv_type r;
      logic     all_one;
      logic     all_zero;
      all_one  = &v[SW-1:DW-1];
      all_zero = ~|v[SW-1:DW-1];
      if (all_one || all_zero) begin
         r.sat = 1'b0;
         r.val = v[DW-1:0];
      end else begin
         r.sat = 1'b1;
         r.val = v[SW-1] ? VAL_MIN : VAL_MAX;
      end
      return r;
   endfunction

   // Build a signed component from sign, quotient magnitude and overflow mark.
   function automatic satv_type pack_mag(input logic neg, input logic [QW-1:0] q,
                                         input logic ovf);
      satv_type r;
      r.sat = 1'b0;
      r.val = q[DW-1:0];
      if (neg && (ovf || q != '0)) begin
         if (ovf || q > MAG_MIN) begin
            r.sat = 1'b1;
            r.val = VAL_MIN;
         end else begin
            r.val = ~q[DW-1:0] + 1'b1;
         end
      end else if (ovf || q[QW-1:DW-1] != '0) begin
         r.sat = 1'b1;
         r.val = VAL_MAX;
      end
      return r;
   endfunction

   function automatic logic [DW-1:0] umag(input logic signed [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ===== design/cea_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module cea_sqrt import cea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [PW-1:0] in_rad,
   input  pld_type       in_pld,
   output logic          out_vld,
   output logic [DW-1:0] out_root,
   output pld_type       out_pld
);

   logic          vld_ff [DW];
   logic [PW-1:0] rem_ff [DW];
   logic [PW-1:0] res_ff [DW];
   pld_type       pld_ff [DW];

   logic          vin [DW];
   logic [PW-1:0] rin [DW];
   logic [PW-1:0] sin [DW];
   pld_type       pin [DW];

   for (genvar k = 0; k < DW; k++) begin : g_stage
      localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2 * k);
      logic [PW-1:0] trial;
      logic          take;

      if (k == 0) begin : g_first
         assign vin[k] = in_vld;
         assign rin[k] = in_rad;
         assign sin[k] = '0;
         assign pin[k] = in_pld;
      end else begin : g_next
         assign vin[k] = vld_ff[k-1];
         assign rin[k] = rem_ff[k-1];
         assign sin[k] = res_ff[k-1];
         assign pin[k] = pld_ff[k-1];
      end

      assign trial = sin[k] + BIT;
      assign take  = rin[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vin[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? rin[k] - trial : rin[k];
            res_ff[k] <= take ? (sin[k] >> 1) + BIT : sin[k] >> 1;
            pld_ff[k] <= pin[k];
         end
      end
   end

   assign out_vld  = vld_ff[DW-1];
   assign out_root = res_ff[DW-1][DW-1:0];
   assign out_pld  = pld_ff[DW-1];

endmodule

// ===== design/cea_div.sv =====
// Two-lane pipelined restoring divider, floor(mag * 2^FW / den), one quotient bit per stage.
module cea_div import cea_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [PW-1:0]       in_den,
   input  logic [1:0][PW-1:0]  in_mag,
   input  pld_type             in_pld,
   output logic                out_vld,
   output logic [1:0][QW-1:0]  out_q,
   output logic [1:0]          out_ovf,
   output pld_type             out_pld
);

   logic                 vld_ff [QW];
   logic [PW-1:0]        den_ff [QW];
   logic [1:0][PW-1:0]   rem_ff [QW];
   logic [1:0][QW-1:0]   q_ff   [QW];
   logic [1:0]           ovf_ff [QW];
   logic [1:0][NLO-1:0]  nlo_ff [QW];
   pld_type              pld_ff [QW];

   logic                 vin [QW];
   logic [PW-1:0]        din [QW];
   logic [1:0][PW-1:0]   rin [QW];
   logic [1:0][QW-1:0]   qin [QW];
   logic [1:0]           oin [QW];
   logic [1:0][NLO-1:0]  nin [QW];
   pld_type              pin [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int BI = QW - 1 - j;
      logic [1:0][PW-1:0] rem_nx;
      logic [1:0]         take;

      if (j == 0) begin : g_first
         assign vin[j] = in_vld;
         assign din[j] = in_den;
         assign pin[j] = in_pld;
         for (genvar l = 0; l < 2; l++) begin : g_lane
            // The quotient needs more than QW bits when the high numerator part reaches den.
            assign rin[j][l] = in_mag[l] >> NLO;
            assign oin[j][l] = (in_mag[l] >> NLO) >= in_den;
            assign qin[j][l] = '0;
            assign nin[j][l] = in_mag[l][NLO-1:0];
         end
      end else begin : g_next
         assign vin[j] = vld_ff[j-1];
         assign din[j] = den_ff[j-1];
         assign pin[j] = pld_ff[j-1];
         assign rin[j] = rem_ff[j-1];
         assign oin[j] = ovf_ff[j-1];
         assign qin[j] = q_ff[j-1];
         assign nin[j] = nlo_ff[j-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane_step
         logic          nbit;
         logic [PW:0]   trial;

         if (BI >= FW) begin : g_nbit
            assign nbit = nin[j][l][BI-FW];
         end else begin : g_zero
            assign nbit = 1'b0;
         end

         assign trial      = {rin[j][l], nbit};
         assign take[l]    = trial >= {1'b0, din[j]};
         assign rem_nx[l]  = take[l] ? PW'(trial - {1'b0, din[j]}) : trial[PW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vin[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[j] <= din[j];
            pld_ff[j] <= pin[j];
            rem_ff[j] <= rem_nx;
            ovf_ff[j] <= oin[j];
            nlo_ff[j] <= nin[j];
            for (int l = 0; l < 2; l++) begin
               q_ff[j][l] <= qin[j][l] | (QW'(take[l]) << BI);
            end
         end
      end
   end

   assign out_vld = vld_ff[QW-1];
   assign out_q   = q_ff[QW-1];
   assign out_ovf = ovf_ff[QW-1];
   assign out_pld = pld_ff[QW-1];

endmodule

// ===== design/complex_elementwise_alu.sv =====
// Top level of the complex element-wise ALU: operand setup, product sums, result packing.
//
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tdata x_re,x_im,y_re,y_im; tuser op; tlast
//  rsp      out        rsp_tvalid/tready     tdata z_re,z_im; tuser status; tlast
//  csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One transaction enters per cycle unless the output stalls, via four setup stages, 32 square
// root stages, 33 divider stages and the output register. Every operation takes the same path.
// A stalled output register freezes the whole pipeline and req_tready drops with it.
// Reset clears valid bits and loads alpha = 1.0, beta = 1.0; csr_ready is always high.
module complex_elementwise_alu import cea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // x_re, x_im, y_re, y_im
   input  logic [3:0]    req_tuser,   // req_type
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // z_re, z_im
   output logic [1:0]    rsp_tuser,   // status
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [3:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam logic [3:0] CSR_ALPHA_RE = 4'd0;
   localparam logic [3:0] CSR_ALPHA_IM = 4'd1;
   localparam logic [3:0] CSR_BETA_RE  = 4'd2;
   localparam logic [3:0] CSR_BETA_IM  = 4'd3;

   typedef struct packed {
      op_type        op;
      logic          last;
      logic [DW-1:0] zr;
      logic [DW-1:0] zi;
      logic          sat;
      logic          xr_neg;
      logic [DW-1:0] xr_mag;
      logic          xi_neg;
      logic [DW-1:0] xi_mag;
   } front_type;

   logic signed [DW-1:0] alpha_re_ff, alpha_im_ff, beta_re_ff, beta_im_ff;

   logic en;

   // input fields
   logic signed [DW-1:0] x_re, x_im, y_re, y_im;
   op_type               op;

   // stage 1
   logic signed [DW-1:0] ma [8];
   logic signed [DW-1:0] mb [8];
   logic [DW-1:0]        ua [2];
   front_type            f1_in;
   satv_type             s_re, s_im;
   logic                 s1_vld_ff;
   front_type            s1_f_ff;
   logic signed [PW-1:0] s1_p_ff [8];
   logic [PW-1:0]        s1_q_ff [2];

   // stage 2
   logic                 s2_vld_ff;
   front_type            s2_f_ff;
   logic signed [SW-1:0] s2_rea_ff, s2_reb_ff, s2_ima_ff, s2_imb_ff;
   logic [PW-1:0]        s2_sqs_ff;
   logic                 conj_sum;

   // stage 3
   logic                 s3_vld_ff;
   front_type            s3_f_ff;
   logic signed [SW-1:0] s3_re_ff, s3_im_ff;
   logic [PW-1:0]        s3_sqs_ff;

   // stage 4
   pld_type              p4_in;
   satv_type             fx_re, fx_im;
   logic [SW-1:0]        abs_re, abs_im;
   logic                 s4_vld_ff;
   pld_type              s4_pld_ff;

   // square root and divider
   logic                 sq_vld;
   logic [DW-1:0]        sq_root;
   pld_type              sq_pld;
   pld_type              dv_pld;
   logic [PW-1:0]        dv_den;
   logic                 dq_vld;
   logic [1:0][QW-1:0]   dq_q;
   logic [1:0]           dq_ovf;
   pld_type              dq_pld;

   // output
   satv_type             o_re, o_im;
   logic [DW-1:0]        fin_re, fin_im;
   status_type           fin_st;
   logic                 rsp_vld_ff;
   logic [63:0]          rsp_data_ff;
   status_type           rsp_st_ff;
   logic                 rsp_last_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_re_ff <= FX_ONE;
         alpha_im_ff <= '0;
         beta_re_ff  <= FX_ONE;
         beta_im_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA_RE: alpha_re_ff <= csr_data;
            CSR_ALPHA_IM: alpha_im_ff <= csr_data;
            CSR_BETA_RE:  beta_re_ff  <= csr_data;
            CSR_BETA_IM:  beta_im_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // advance only when the output register can take what comes
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   assign x_re = req_tdata[31:0];
   assign x_im = req_tdata[63:32];
   assign y_re = req_tdata[95:64];
   assign y_im = req_tdata[127:96];
   assign op   = op_type'(req_tuser);

   // stage 1: operand selection, multipliers and the plain add-type results
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         ma[i] = '0;
         mb[i] = '0;
      end
      ua[0]       = '0;
      ua[1]       = '0;
      s_re        = '0;
      s_im        = '0;
      f1_in.op     = op;
      f1_in.last   = req_tlast;
      f1_in.xr_neg = x_re[DW-1];
      f1_in.xr_mag = umag(x_re);
      f1_in.xi_neg = x_im[DW-1];
      f1_in.xi_mag = umag(x_im);
      unique case (op)
         OP_CONJ: begin
            s_re = sat_wide(SW'(x_re));
            s_im = sat_wide(-SW'(x_im));
         end
         OP_SHIFT: begin
            s_re = sat_wide(SW'(alpha_re_ff) + SW'(x_re));
            s_im = sat_wide(SW'(alpha_im_ff) + SW'(x_im));
         end
         OP_NEG: begin
            s_re = sat_wide(-SW'(x_re));
            s_im = sat_wide(-SW'(x_im));
         end
         OP_ADD: begin
            s_re = sat_wide(SW'(x_re) + SW'(y_re));
            s_im = sat_wide(SW'(x_im) + SW'(y_im));
         end
         OP_SUB: begin
            s_re = sat_wide(SW'(x_re) - SW'(y_re));
            s_im = sat_wide(SW'(x_im) - SW'(y_im));
         end
         OP_SCALE, OP_AXPBY: begin
            ma[0] = alpha_re_ff; mb[0] = x_re;
            ma[1] = alpha_im_ff; mb[1] = x_im;
            ma[2] = alpha_re_ff; mb[2] = x_im;
            ma[3] = alpha_im_ff; mb[3] = x_re;
            if (op == OP_AXPBY) begin
               ma[4] = beta_re_ff; mb[4] = y_re;
               ma[5] = beta_im_ff; mb[5] = y_im;
               ma[6] = beta_re_ff; mb[6] = y_im;
               ma[7] = beta_im_ff; mb[7] = y_re;
            end
         end
         OP_MUL, OP_DIV: begin
            ma[0] = x_re; mb[0] = y_re;
            ma[1] = x_im; mb[1] = y_im;
            ma[2] = x_re; mb[2] = y_im;
            ma[3] = x_im; mb[3] = y_re;
            if (op == OP_DIV) begin
               ua[0] = umag(y_re);
               ua[1] = umag(y_im);
            end
         end
         OP_INV: begin
            ma[0] = FX_ONE; mb[0] = x_re;
            ma[2] = FX_ONE; mb[2] = x_im;
            ua[0] = umag(x_re);
            ua[1] = umag(x_im);
         end
         OP_ABS, OP_SGN: begin
            ua[0] = umag(x_re);
            ua[1] = umag(x_im);
         end
         default: ;
      endcase
      f1_in.zr  = s_re.val;
      f1_in.zi  = s_im.val;
      f1_in.sat = s_re.sat | s_im.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_f_ff <= f1_in;
         for (int i = 0; i < 8; i++) begin
            s1_p_ff[i] <= ma[i] * mb[i];
         end
         for (int i = 0; i < 2; i++) begin
            s1_q_ff[i] <= ua[i] * ua[i];
         end
      end
   end

   // stage 2: pair sums; division numerators take a times conj(b)
   assign conj_sum = (s1_f_ff.op == OP_DIV) || (s1_f_ff.op == OP_INV);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_f_ff   <= s1_f_ff;
         s2_rea_ff <= conj_sum ? SW'(s1_p_ff[0]) + SW'(s1_p_ff[1])
                               : SW'(s1_p_ff[0]) - SW'(s1_p_ff[1]);
         s2_reb_ff <= SW'(s1_p_ff[4]) - SW'(s1_p_ff[5]);
         s2_ima_ff <= conj_sum ? SW'(s1_p_ff[3]) - SW'(s1_p_ff[2])
                               : SW'(s1_p_ff[2]) + SW'(s1_p_ff[3]);
         s2_imb_ff <= SW'(s1_p_ff[6]) + SW'(s1_p_ff[7]);
         s2_sqs_ff <= s1_q_ff[0] + s1_q_ff[1];
      end
   end

   // stage 3: full sums
   always_ff @(posedge clock) begin
      if (en) begin
         s3_f_ff   <= s2_f_ff;
         s3_re_ff  <= s2_rea_ff + s2_reb_ff;
         s3_im_ff  <= s2_ima_ff + s2_imb_ff;
         s3_sqs_ff <= s2_sqs_ff;
      end
   end

   // stage 4: fixed-point results and divider numerators
   always_comb begin
      fx_re  = sat_wide(s3_re_ff >>> FW);
      fx_im  = sat_wide(s3_im_ff >>> FW);
      abs_re = s3_re_ff[SW-1] ? -s3_re_ff : s3_re_ff;
      abs_im = s3_im_ff[SW-1] ? -s3_im_ff : s3_im_ff;

      p4_in.op     = s3_f_ff.op;
      p4_in.last   = s3_f_ff.last;
      p4_in.sqs    = s3_sqs_ff;
      p4_in.zr     = s3_f_ff.zr;
      p4_in.zi     = s3_f_ff.zi;
      p4_in.sat    = s3_f_ff.sat;
      p4_in.nr_neg = s3_re_ff[SW-1];
      p4_in.nr_mag = abs_re[PW-1:0];
      p4_in.ni_neg = s3_im_ff[SW-1];
      p4_in.ni_mag = abs_im[PW-1:0];
      if (s3_f_ff.op == OP_SCALE || s3_f_ff.op == OP_AXPBY || s3_f_ff.op == OP_MUL) begin
         p4_in.zr  = fx_re.val;
         p4_in.zi  = fx_im.val;
         p4_in.sat = fx_re.sat | fx_im.sat;
      end
      if (s3_f_ff.op == OP_SGN) begin
         p4_in.nr_neg = s3_f_ff.xr_neg;
         p4_in.nr_mag = PW'(s3_f_ff.xr_mag);
         p4_in.ni_neg = s3_f_ff.xi_neg;
         p4_in.ni_mag = PW'(s3_f_ff.xi_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_pld_ff <= p4_in;
      end
   end

   cea_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s4_vld_ff),
      .in_rad   (s4_pld_ff.sqs),
      .in_pld   (s4_pld_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_pld  (sq_pld)
   );

   // magnitude lands here; sgn divides by the root, inv and div by the sum of squares
   always_comb begin
      dv_pld = sq_pld;
      dv_den = sq_pld.sqs;
      if (sq_pld.op == OP_ABS) begin
         dv_pld.zr  = sq_root[DW-1] ? VAL_MAX : sq_root;
         dv_pld.zi  = '0;
         dv_pld.sat = sq_root[DW-1];
      end
      if (sq_pld.op == OP_SGN) begin
         dv_den = PW'(sq_root);
      end
   end

   cea_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sq_vld),
      .in_den  (dv_den),
      .in_mag  ({dv_pld.ni_mag, dv_pld.nr_mag}),
      .in_pld  (dv_pld),
      .out_vld (dq_vld),
      .out_q   (dq_q),
      .out_ovf (dq_ovf),
      .out_pld (dq_pld)
   );

   // final packing
   always_comb begin
      o_re   = pack_mag(dq_pld.nr_neg, dq_q[0], dq_ovf[0]);
      o_im   = pack_mag(dq_pld.ni_neg, dq_q[1], dq_ovf[1]);
      fin_re = dq_pld.zr;
      fin_im = dq_pld.zi;
      fin_st = dq_pld.sat ? ST_SAT : ST_OK;
      unique case (dq_pld.op)
         OP_SGN: begin
            if (dq_pld.sqs == '0) begin
               fin_re = '0;
               fin_im = '0;
               fin_st = ST_OK;
            end else begin
               fin_re = o_re.val;
               fin_im = o_im.val;
               fin_st = (o_re.sat | o_im.sat) ? ST_SAT : ST_OK;
            end
         end
         OP_INV, OP_DIV: begin
            if (dq_pld.sqs == '0) begin
               fin_re = '0;
               fin_im = '0;
               fin_st = ST_DIVZ;
            end else begin
               fin_re = o_re.val;
               fin_im = o_im.val;
               fin_st = (o_re.sat | o_im.sat) ? ST_SAT : ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {fin_im, fin_re};
         rsp_st_ff   <= fin_st;
         rsp_last_ff <= dq_pld.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while output stalled");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_DIVZ) |-> (rsp_tdata == '0))
      else $error("divide by zero with nonzero result");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_SAT) |->
         (rsp_tdata[31:0] == VAL_MAX || rsp_tdata[31:0] == VAL_MIN ||
          rsp_tdata[63:32] == VAL_MAX || rsp_tdata[63:32] == VAL_MIN))
      else $error("saturation flagged without a clamped component");

endmodule

// ===== verif/complex_elementwise_alu_checker.sv =====
// Checker for the complex element-wise ALU: predicts every result and compares it.
module complex_elementwise_alu_checker import cea_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // x_re, x_im, y_re, y_im
   input  logic [3:0]   req_tuser,   // req_type
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,   // z_re, z_im
   input  logic [1:0]   rsp_tuser,   // status
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   localparam logic [3:0] REG_ALPHA_RE = 4'd0;
   localparam logic [3:0] REG_ALPHA_IM = 4'd1;
   localparam logic [3:0] REG_BETA_RE  = 4'd2;
   localparam logic [3:0] REG_BETA_IM  = 4'd3;

   typedef logic signed [127:0] wide_t;

   typedef struct {
      logic [31:0] z_re;
      logic [31:0] z_im;
      status_type  status;
      logic        last;
   } cplx_result_t;

   cplx_result_t result_q[$];
   logic signed [31:0] alpha_re, alpha_im, beta_re, beta_im;

   function automatic logic [31:0] clamp(input wide_t v, inout logic sat);
      if (v > wide_t'(32'sh7fffffff)) begin
         sat = 1'b1;
         return VAL_MAX;
      end
      if (v < -wide_t'(64'sh80000000)) begin
         sat = 1'b1;
         return VAL_MIN;
      end
      return v[31:0];
   endfunction

   // Signed component from a sign and an unsigned quotient magnitude.
   function automatic logic [31:0] from_mag(input logic neg, input logic [127:0] q,
                                            inout logic sat);
      if (neg && q != 0) begin
         if (q > 128'h80000000) begin
            sat = 1'b1;
            return VAL_MIN;
         end
         return ~q[31:0] + 1'b1;
      end
      if (q > 128'h7fffffff) begin
         sat = 1'b1;
         return VAL_MAX;
      end
      return q[31:0];
   endfunction

   function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
      logic [127:0] root, bitv;
      root = 0;
      bitv = 128'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [127:0] absw(input wide_t v);
      return v < 0 ? -v : v;
   endfunction

   // Quotient a / b computed as a * conj(b) / |b|^2; returns 0 on a zero divisor.
   function automatic logic cplx_quotient(input wide_t ar, input wide_t ai, input wide_t br,
                                          input wide_t bi, output logic [31:0] zr,
                                          output logic [31:0] zi, inout logic sat);
      logic [127:0] den;
      wide_t nr, ni;
      den = br * br + bi * bi;
      zr = '0;
      zi = '0;
      if (den == 0) return 1'b0;
      nr = ar * br + ai * bi;
      ni = ai * br - ar * bi;
      zr = from_mag(nr < 0, (absw(nr) << FW) / den, sat);
      zi = from_mag(ni < 0, (absw(ni) << FW) / den, sat);
      return 1'b1;
   endfunction

   function automatic cplx_result_t compute_element(input logic [3:0] code,
                                                    input logic [127:0] data,
                                                    input logic last);
      cplx_result_t r;
      wide_t xr, xi, yr, yi, ar, ai, br, bi;
      logic [127:0] root;
      logic sat, ok;
      xr = wide_t'($signed(data[31:0]));
      xi = wide_t'($signed(data[63:32]));
      yr = wide_t'($signed(data[95:64]));
      yi = wide_t'($signed(data[127:96]));
      ar = wide_t'(alpha_re);
      ai = wide_t'(alpha_im);
      br = wide_t'(beta_re);
      bi = wide_t'(beta_im);
      sat = 1'b0;
      ok = 1'b1;
      r.z_re = '0;
      r.z_im = '0;
      r.last = last;
      case (op_type'(code))
         OP_CONJ: begin
            r.z_re = clamp(xr, sat);
            r.z_im = clamp(-xi, sat);
         end
         OP_SCALE: begin
            r.z_re = clamp((ar * xr - ai * xi) >>> FW, sat);
            r.z_im = clamp((ar * xi + ai * xr) >>> FW, sat);
         end
         OP_SHIFT: begin
            r.z_re = clamp(ar + xr, sat);
            r.z_im = clamp(ai + xi, sat);
         end
         OP_NEG: begin
            r.z_re = clamp(-xr, sat);
            r.z_im = clamp(-xi, sat);
         end
         OP_ABS: r.z_re = from_mag(1'b0, floor_sqrt(xr * xr + xi * xi), sat);
         OP_SGN: begin
            root = floor_sqrt(xr * xr + xi * xi);
            if (root != 0) begin
               r.z_re = from_mag(xr < 0, (absw(xr) << FW) / root, sat);
               r.z_im = from_mag(xi < 0, (absw(xi) << FW) / root, sat);
            end
         end
         OP_INV: ok = cplx_quotient(wide_t'(FX_ONE), 0, xr, xi, r.z_re, r.z_im, sat);
         OP_AXPBY: begin
            r.z_re = clamp((ar * xr - ai * xi + br * yr - bi * yi) >>> FW, sat);
            r.z_im = clamp((ar * xi + ai * xr + br * yi + bi * yr) >>> FW, sat);
         end
         OP_ADD: begin
            r.z_re = clamp(xr + yr, sat);
            r.z_im = clamp(xi + yi, sat);
         end
         OP_SUB: begin
            r.z_re = clamp(xr - yr, sat);
            r.z_im = clamp(xi - yi, sat);
         end
         OP_MUL: begin
            r.z_re = clamp((xr * yr - xi * yi) >>> FW, sat);
            r.z_im = clamp((xr * yi + xi * yr) >>> FW, sat);
         end
         OP_DIV: ok = cplx_quotient(xr, xi, yr, yi, r.z_re, r.z_im, sat);
         default: ;
      endcase
      if (!ok) begin
         r.z_re = '0;
         r.z_im = '0;
         r.status = ST_DIVZ;
      end else begin
         r.status = sat ? ST_SAT : ST_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cplx_result_t want;
      if (reset) begin
         alpha_re = FX_ONE;
         alpha_im = '0;
         beta_re = FX_ONE;
         beta_im = '0;
         result_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result z=%h status=%0d last=%b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_tdata[31:0] !== want.z_re || rsp_tdata[63:32] !== want.z_im ||
                   rsp_tuser !== want.status || rsp_tlast !== want.last) begin
                  $display("%0t: mismatch expected re=%h im=%h st=%0d last=%b", $time,
                           want.z_re, want.z_im, want.status, want.last);
                  $display("%0t:          actual   re=%h im=%h st=%0d last=%b", $time,
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            result_q.push_back(compute_element(req_tuser, req_tdata, req_tlast));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ALPHA_RE: alpha_re = csr_data;
               REG_ALPHA_IM: alpha_im = csr_data;
               REG_BETA_RE:  beta_re = csr_data;
               REG_BETA_IM:  beta_im = csr_data;
               default: ;
            endcase
         end
      end
      pending = result_q.size();
   end

endmodule

// ===== verif/complex_elementwise_alu_tb.sv =====
// Testbench top for the complex element-wise ALU: stimulus, output stalls and verdict.
module complex_elementwise_alu_tb;
   import cea_pkg::*;

   localparam logic [3:0] REG_ALPHA_RE = 4'd0;
   localparam logic [3:0] REG_ALPHA_IM = 4'd1;
   localparam logic [3:0] REG_BETA_RE  = 4'd2;
   localparam logic [3:0] REG_BETA_IM  = 4'd3;
   localparam int         DRAIN_CYCLES = 80;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [3:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;
   int           fail_count;
   int           pending;
   int           rsp_hold = 0;
   logic         gaps_on = 1'b0;
   logic         stalls_on = 1'b0;

   always #5 clock = ~clock;

   complex_elementwise_alu dut (.*);
   complex_elementwise_alu_checker checker_i (.*);

   // Switch between stretches with and without idling.
   always @(posedge clock) begin
      if ($urandom_range(0, 150) == 0) gaps_on <= ~gaps_on;
      if ($urandom_range(0, 150) == 0) stalls_on <= ~stalls_on;
   end

   always @(posedge clock) begin
      int d;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (!rsp_tready) begin
         if (rsp_hold == 0) rsp_tready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end else if (rsp_tvalid) begin
         d = stalls_on ? $urandom_range(0, 12) : 0;
         if (d != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold <= d - 1;
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return '0;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         6: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_element(input logic [3:0] code, input logic [31:0] xr,
                               input logic [31:0] xi, input logic [31:0] yr,
                               input logic [31:0] yi, input logic last);
      int gap;
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {yi, yr, xi, xr};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Leave csr_valid high so that writes can follow back to back.
   task automatic write_reg(input logic [3:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Hold until the pipeline is empty, then load a new alpha and beta.
   task automatic load_coeffs(input logic [31:0] are, input logic [31:0] aim,
                              input logic [31:0] bre, input logic [31:0] bim);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(REG_ALPHA_RE, are);
      write_reg(REG_ALPHA_IM, aim);
      write_reg(REG_BETA_RE, bre);
      write_reg(REG_BETA_IM, bim);
      csr_valid <= 1'b0;
   endtask

   task automatic random_elements(input int count);
      logic [3:0] code;
      logic [31:0] yr, yi;
      for (int i = 0; i < count; i++) begin
         code = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(OP_CONJ, OP_DIV));
         yr = pick_value();
         yi = pick_value();
         // Make a zero divisor now and then.
         if (code == OP_DIV && $urandom_range(0, 15) == 0) begin
            yr = '0;
            yi = '0;
         end
         send_element(code, pick_value(), pick_value(), yr, yi, 1'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation at the range limits and the special cases.
      for (int op = OP_CONJ; op <= OP_DIV; op++)
         send_element(4'(op), VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 1'(op));
      send_element(OP_NEG, VAL_MIN, VAL_MIN, '0, '0, 1'b0);
      send_element(OP_SGN, '0, '0, '0, '0, 1'b1);
      send_element(OP_INV, '0, '0, '0, '0, 1'b0);
      send_element(OP_DIV, FX_ONE, FX_ONE, '0, '0, 1'b1);
      send_element(OP_INV, 32'h1, '0, '0, '0, 1'b0);
      send_element(OP_ABS, VAL_MIN, VAL_MIN, '0, '0, 1'b1);
      send_element(OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff, 1'b0);
      send_element(OP_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00020000, 1'b1);
      send_element(4'd12, 32'h5, 32'h6, 32'h7, 32'h8, 1'b1);
      send_element(4'd15, '1, '1, '1, '1, 1'b0);
      random_elements(150);

      load_coeffs(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
      random_elements(200);
      load_coeffs('0, '0, '0, '0);
      random_elements(100);
      load_coeffs(32'hffff0000, 32'h00008000, 32'h00020000, 32'hfffffffe);
      random_elements(200);
      load_coeffs($urandom, $urandom, $urandom, $urandom);
      random_elements(150);
      load_coeffs(32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                  32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                  32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                  32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
      random_elements(200);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/cea_pkg.sv
design/cea_sqrt.sv
design/cea_div.sv
design/complex_elementwise_alu.sv
verif/complex_elementwise_alu_checker.sv
verif/complex_elementwise_alu_tb.sv
